[sv/pdoc_pkg.sv]
// ----------------------------------------------------------------------------
// pdoc_pkg
// Shared constants and code values for the record decompressor.
// ----------------------------------------------------------------------------
package pdoc_pkg;

    localparam int PDOC_LENGTH_BITS  = 3;
    localparam int PDOC_WINDOW_DEPTH = 2048;

    // pair word and literal run counter
    localparam int WORD_BITS = 14;
    localparam int LIT_BITS  = 4;
    localparam int PAIR_HIGH_BITS = 6;

    // code byte classes
    localparam logic [7:0] LIT_RUN_MIN = 8'h01;
    localparam logic [7:0] LIT_RUN_MAX = 8'h08;
    localparam logic [7:0] PAIR_BASE   = 8'h80;
    localparam logic [7:0] SPACE_BASE  = 8'hC0;
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] SPACE_XOR   = 8'h80;

endpackage

[sv/pdoc_ram.sv]
// ----------------------------------------------------------------------------
// pdoc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pdoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/palmdoc_decompressor.sv]
// ----------------------------------------------------------------------------
// palmdoc_decompressor
// Takes one compressed byte per input word and returns the decompressed
// bytes, one per output word, with run_last on the final byte of each input
// word. Plain and literal-run bytes are emitted on acceptance; a space code
// emits a space, then the code byte XOR SPACE_XOR from ST_SPACE2. A
// back-reference starts on the pair's second byte and copies 3 to
// 2**LENGTH_BITS+2 bytes, each in a ST_CP_RD then ST_CP_WR step: every copy
// byte is read from the history RAM through its registered read port, and is
// written back before the next read, so overlapping copies see their own
// output. The pair's first byte and literal-run counts produce no output. A
// new input word is taken once the previous one is fully emitted and the
// output register is free or being drained. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module palmdoc_decompressor
    import pdoc_pkg::*;
#(
    parameter int LENGTH_BITS  = PDOC_LENGTH_BITS,
    parameter int WINDOW_DEPTH = PDOC_WINDOW_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_code_byte,
    input  logic       s_record_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_text_byte,
    output logic       m_run_last,
    output logic       m_bad_distance
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int DW = WORD_BITS - LENGTH_BITS;
    localparam int SW = ((AW > DW) ? AW : DW) + 1;
    localparam int CW = LENGTH_BITS + 1;

    localparam logic [SW-1:0] DEPTH_S   = SW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] WP_LAST   = AW'(WINDOW_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(WINDOW_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPACE2,
        ST_CP_RD,
        ST_CP_WR
    } state_t;

    state_t                    state_reg, state_next;
    logic [AW-1:0]             wp_reg, wp_next;
    logic [FW-1:0]             fill_reg, fill_next;
    logic [LIT_BITS-1:0]       lit_reg, lit_next;
    logic                      pair_reg, pair_next;
    logic [PAIR_HIGH_BITS-1:0] high_reg, high_next;
    logic                      end_reg, end_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [DW-1:0]             dist_reg, dist_next;
    logic                      bad_reg, bad_next;
    logic [7:0]                hold_reg, hold_next;
    logic                      m_valid_reg, m_valid_next;
    logic [7:0]                m_text_byte_reg, m_text_byte_next;
    logic                      m_run_last_reg, m_run_last_next;
    logic                      m_bad_distance_reg, m_bad_distance_next;

    logic                      out_free;
    logic                      accept;
    logic                      emit;
    logic [7:0]                emit_byte;
    logic                      emit_bad;
    logic                      emit_last;
    logic                      clear_fill;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [7:0]                ram_rdata;
    logic [WORD_BITS-1:0]      pair_word;
    logic [SW-1:0]             src_diff;
    logic [SW-1:0]             dist_ext;

    pdoc_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (emit),
        .wr_addr (wp_reg),
        .wr_data (emit_byte),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign pair_word = {high_reg, s_code_byte};
    assign dist_ext  = SW'(dist_reg);
    assign src_diff  = SW'(wp_reg) - dist_ext;
    assign ram_raddr = src_diff[SW-1] ? AW'(src_diff + DEPTH_S) : src_diff[AW-1:0];

    always_comb begin
        state_next          = state_reg;
        wp_next             = wp_reg;
        fill_next           = fill_reg;
        lit_next            = lit_reg;
        pair_next           = pair_reg;
        high_next           = high_reg;
        end_next            = end_reg;
        cnt_next            = cnt_reg;
        dist_next           = dist_reg;
        bad_next            = bad_reg;
        hold_next           = hold_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_text_byte_next    = m_text_byte_reg;
        m_run_last_next     = m_run_last_reg;
        m_bad_distance_next = m_bad_distance_reg;
        emit       = 1'b0;
        emit_byte  = 8'h00;
        emit_bad   = 1'b0;
        emit_last  = 1'b1;
        clear_fill = 1'b0;
        ram_re     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    end_next   = s_record_end;
                    clear_fill = s_record_end;
                    if (lit_reg != '0) begin
                        emit      = 1'b1;
                        emit_byte = s_code_byte;
                        lit_next  = lit_reg - 1'b1;
                    end else if (pair_reg) begin
                        pair_next  = 1'b0;
                        dist_next  = pair_word[WORD_BITS-1:LENGTH_BITS];
                        cnt_next   = CW'(pair_word[LENGTH_BITS-1:0]) + CW'(3);
                        state_next = ST_CP_RD;
                        clear_fill = 1'b0;
                    end else if (s_code_byte inside {[LIT_RUN_MIN:LIT_RUN_MAX]}) begin
                        lit_next = s_code_byte[LIT_BITS-1:0];
                    end else if (s_code_byte < PAIR_BASE) begin
                        emit      = 1'b1;
                        emit_byte = s_code_byte;
                    end else if (s_code_byte >= SPACE_BASE) begin
                        emit       = 1'b1;
                        emit_byte  = SPACE_CHAR;
                        emit_last  = 1'b0;
                        hold_next  = s_code_byte ^ SPACE_XOR;
                        state_next = ST_SPACE2;
                        clear_fill = 1'b0;
                    end else begin
                        pair_next = 1'b1;
                        high_next = s_code_byte[PAIR_HIGH_BITS-1:0];
                    end
                    if (s_record_end) begin
                        lit_next  = '0;
                        pair_next = 1'b0;
                        high_next = '0;
                    end
                end
            end
            ST_SPACE2: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_byte  = hold_reg;
                    clear_fill = end_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_CP_RD: begin
                ram_re     = 1'b1;
                bad_next   = (dist_reg == '0) || (dist_ext > SW'(fill_reg))
                             || (dist_ext > DEPTH_S);
                state_next = ST_CP_WR;
            end
            ST_CP_WR: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_byte = bad_reg ? 8'h00 : ram_rdata;
                    emit_bad  = bad_reg;
                    emit_last = (cnt_reg == CW'(1));
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        clear_fill = end_reg;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_CP_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next        = 1'b1;
            m_text_byte_next    = emit_byte;
            m_run_last_next     = emit_last;
            m_bad_distance_next = emit_bad;
            wp_next             = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
            if (fill_reg < FILL_MAX) begin
                fill_next = fill_reg + 1'b1;
            end
        end
        if (clear_fill) begin
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            fill_reg    <= '0;
            lit_reg     <= '0;
            pair_reg    <= 1'b0;
            high_reg    <= '0;
            end_reg     <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            lit_reg     <= lit_next;
            pair_reg    <= pair_next;
            high_reg    <= high_next;
            end_reg     <= end_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        dist_reg           <= dist_next;
        bad_reg            <= bad_next;
        hold_reg           <= hold_next;
        m_text_byte_reg    <= m_text_byte_next;
        m_run_last_reg     <= m_run_last_next;
        m_bad_distance_reg <= m_bad_distance_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_text_byte    = m_text_byte_reg;
    assign m_run_last     = m_run_last_reg;
    assign m_bad_distance = m_bad_distance_reg;

`ifndef SYNTHESIS
    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_bad_distance_reg) |-> (m_text_byte_reg == 8'h00))
        else $error("bad distance word carries nonzero byte");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("fill count above window depth");

    a_wp_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && emit) |=> (wp_reg != $past(wp_reg)))
        else $error("write position did not advance on ring write");

    a_copy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_CP_RD) || (state_reg == ST_CP_WR)) |-> (cnt_reg != '0))
        else $error("copy active with zero count");

    a_rd_then_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CP_RD) |=> (state_reg == ST_CP_WR))
        else $error("ring read not followed by copy write");
`endif

endmodule
